// ===== hw/rtl/xor_checked_frame_decoder_unit_defines.svh =====
// Assertion macros shared by the frame decoder RTL.
// Every macro samples on clk and is disabled while arst_n is low.
// Defining ASSERT_OFF compiles all of them to nothing.
`ifndef XOR_CHECKED_FRAME_DECODER_UNIT_DEFINES_SVH
`define XOR_CHECKED_FRAME_DECODER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define XCFD_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("xcfd assertion failed");
// Condition must never be true at a clock edge outside reset.
`define XCFD_ASSERT_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("xcfd forbidden condition seen");
`else
`define XCFD_ASSERT(lbl, prop)
`define XCFD_ASSERT_NEVER(lbl, cond)
`endif

`endif

// ===== hw/rtl/xcfd_pkg.sv =====
// Shared constants, the result record and BCD helpers of the frame decoder.
// Depends on nothing; every other RTL file but the assertion header imports it.
`default_nettype none

package xcfd_pkg;

	localparam int unsigned MAX_FRAME_LEN_DEF = 255;
	localparam int unsigned MIN_FRAME_LEN     = 14;
	localparam int unsigned PAYLOAD_FIRST     = 2;
	localparam int unsigned PAYLOAD_LEN       = 9;

	localparam logic [7:0] HDR_BYTE = 8'hAF;
	localparam logic [7:0] END_BYTE = 8'hFA;

	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_CSUM_BAD   = 3'd1;
	localparam logic [2:0] ST_HDR_REJECT = 3'd2;
	localparam logic [2:0] ST_TOO_SHORT  = 3'd3;
	localparam logic [2:0] ST_TOO_LONG   = 3'd4;

	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  order_code;
		logic [7:0]  pump_number;
		logic [13:0] year;
		logic [6:0]  month;
		logic [6:0]  day;
		logic [6:0]  hour;
		logic [6:0]  minute;
		logic [6:0]  second;
	} xcfd_result_t;

	function automatic logic bcd_ok(input logic [7:0] b);
		return (b[7:4] <= 4'd9) && (b[3:0] <= 4'd9);
	endfunction

	// Two BCD digits to binary; an invalid nibble makes the field zero.
	function automatic logic [6:0] bcd2(input logic [7:0] b);
		logic [6:0] v;
		v = 7'(b[7:4]) * 7'd10 + 7'(b[3:0]);
		return bcd_ok(b) ? v : 7'd0;
	endfunction

	// Four BCD digits (high byte first) to binary.
	function automatic logic [13:0] bcd4(input logic [7:0] hi, input logic [7:0] lo);
		logic [13:0] v;
		v = 14'(bcd2(hi)) * 14'd100 + 14'(bcd2(lo));
		return (bcd_ok(hi) && bcd_ok(lo)) ? v : 14'd0;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/xcfd_in_stage.sv =====
// Input register of the frame decoder: one received byte is held here
// until the frame logic takes it. Depends on xcfd_pkg only for style.
`default_nettype none

module xcfd_in_stage
	import xcfd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] rx_byte,
	input  wire logic       advance,
	output logic            valid_s1,
	output logic [7:0]      byte_s1
);

	logic load;

	// The register refills when it is empty or its byte moves on this cycle.
	assign load     = !valid_s1 || advance;
	assign in_stall = !load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load && in_valid) begin
			byte_s1 <= rx_byte;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/xcfd_frame_core.sv =====
// Frame state and per-byte decision logic: header check, running XOR,
// fixed-position capture, end detection and BCD decode. Uses xcfd_pkg.
`default_nettype none
`include "xor_checked_frame_decoder_unit_defines.svh"

module xcfd_frame_core
	import xcfd_pkg::*;
#(
	parameter int unsigned MAX_FRAME_LEN = MAX_FRAME_LEN_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       en,
	input  wire logic [7:0] byte_s1,
	output logic            res_valid,
	output xcfd_result_t    res
);

	localparam int unsigned CNT_W = $clog2(MAX_FRAME_LEN + 1);
	localparam logic [CNT_W-1:0] MAX_N = CNT_W'(MAX_FRAME_LEN);
	localparam logic [CNT_W-1:0] MIN_N = CNT_W'(MIN_FRAME_LEN);

	logic [CNT_W-1:0] cnt_q, cnt_d, n;
	logic             first_ok_q, first_ok_d;
	logic [7:0]       xor_q, xor_d, xor_nx, sum;
	// The newest byte is byte_s1 itself; these hold the two before it.
	logic [7:0]       recent_q [2];
	logic [7:0]       payload_q [PAYLOAD_LEN];
	logic             restart, is_end;
	xcfd_result_t     data_res;

	assign n      = cnt_q + CNT_W'(1);
	assign xor_nx = xor_q ^ byte_s1;
	// Newest byte and the one before it both carry the end marker.
	assign is_end = (byte_s1 == END_BYTE) && (recent_q[0] == END_BYTE);
	// Remove the last three bytes from the running XOR; compare to the third last.
	assign sum    = xor_nx ^ byte_s1 ^ recent_q[0] ^ recent_q[1];

	always_comb begin
		data_res             = '0;
		data_res.status      = (sum == recent_q[1]) ? ST_OK : ST_CSUM_BAD;
		data_res.order_code  = payload_q[0];
		data_res.pump_number = payload_q[1];
		data_res.year        = bcd4(payload_q[2], payload_q[3]);
		data_res.month       = bcd2(payload_q[4]);
		data_res.day         = bcd2(payload_q[5]);
		data_res.hour        = bcd2(payload_q[6]);
		data_res.minute      = bcd2(payload_q[7]);
		data_res.second      = bcd2(payload_q[8]);
	end

	always_comb begin
		res_valid  = 1'b0;
		res        = '0;
		restart    = 1'b0;
		cnt_d      = cnt_q;
		first_ok_d = first_ok_q;
		xor_d      = xor_q;
		if (cnt_q == CNT_W'(0)) begin
			first_ok_d = (byte_s1 == HDR_BYTE);
			cnt_d      = CNT_W'(1);
		end else if (cnt_q == CNT_W'(1)) begin
			if (!first_ok_q || (byte_s1 != HDR_BYTE)) begin
				res_valid  = 1'b1;
				res.status = ST_HDR_REJECT;
				restart    = 1'b1;
			end else begin
				cnt_d = CNT_W'(2);
			end
		end else begin
			xor_d = xor_nx;
			if (is_end) begin
				res_valid = 1'b1;
				restart   = 1'b1;
				if (n < MIN_N) begin
					res.status = ST_TOO_SHORT;
				end else begin
					res = data_res;
				end
			end else if (n >= MAX_N) begin
				res_valid  = 1'b1;
				res.status = ST_TOO_LONG;
				restart    = 1'b1;
			end else begin
				cnt_d = n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			first_ok_q  <= 1'b0;
			xor_q       <= '0;
			recent_q[0] <= '0;
			recent_q[1] <= '0;
		end else if (en) begin
			if (restart) begin
				cnt_q       <= '0;
				first_ok_q  <= 1'b0;
				xor_q       <= '0;
				recent_q[0] <= '0;
				recent_q[1] <= '0;
			end else begin
				cnt_q       <= cnt_d;
				first_ok_q  <= first_ok_d;
				xor_q       <= xor_d;
				recent_q[0] <= byte_s1;
				recent_q[1] <= recent_q[0];
			end
		end
	end

	// Each captured byte has a fixed slot selected by the frame position.
	for (genvar k = 0; k < PAYLOAD_LEN; k++) begin : g_payload
		always_ff @(posedge clk) begin
			if (en && (cnt_q == CNT_W'(k + PAYLOAD_FIRST))) begin
				payload_q[k] <= byte_s1;
			end
		end
	end

	`XCFD_ASSERT_NEVER(a_cnt_below_max, cnt_q >= MAX_N)
	`XCFD_ASSERT(a_restart_clears, (en && res_valid) |=> (cnt_q == CNT_W'(0)))
	`XCFD_ASSERT(a_hdr_only_at_second,
		(res_valid && (res.status == ST_HDR_REJECT)) |-> (cnt_q == CNT_W'(1)))
	`XCFD_ASSERT(a_no_data_on_error,
		(res_valid && (res.status != ST_OK) && (res.status != ST_CSUM_BAD))
		|-> (res.order_code == 8'd0 && res.pump_number == 8'd0 && res.year == 14'd0))

endmodule

`default_nettype wire

// ===== hw/rtl/xcfd_out_reg.sv =====
// Result register of the frame decoder; holds one report until it is taken.
// Uses the result record from xcfd_pkg.
`default_nettype none

module xcfd_out_reg
	import xcfd_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          load,
	input  wire xcfd_result_t  res,
	input  wire logic          out_stall,
	output logic               out_valid,
	output logic               blocked,
	output xcfd_result_t       res_q
);

	// A held report that is not taken this cycle blocks the frame logic.
	assign blocked = out_valid && out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/xor_checked_frame_decoder_unit.sv =====
// out_valid rises at the edge where the frame logic takes the byte that closes
// or rejects a frame, as that edge loads the report into the result register.
// Throughput: one byte per cycle unless blocked; the only path is input register, frame logic, result register.
// A report held under out_stall blocks the frame logic, which then stalls the input.
// Reset: arst_n low clears the frame count, header flag, running XOR, recent bytes
// and both valid flags; captured frame bytes are not reset.
`default_nettype none

module xor_checked_frame_decoder_unit
	import xcfd_pkg::*;
#(
	parameter int unsigned MAX_FRAME_LEN = MAX_FRAME_LEN_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] rx_byte,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [2:0]      status,
	output logic [7:0]      order_code,
	output logic [7:0]      pump_number,
	output logic [13:0]     year,
	output logic [6:0]      month,
	output logic [6:0]      day,
	output logic [6:0]      hour,
	output logic [6:0]      minute,
	output logic [6:0]      second
);

	// Stage one holds the received byte. The frame logic consumes it whenever
	// the result register is free or being emptied in the same cycle.
	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         blocked;
	logic         advance;
	logic         en;
	logic         res_valid;
	xcfd_result_t res;
	xcfd_result_t res_q;

	assign advance = !blocked;
	assign en      = valid_s1 && advance;

	xcfd_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.rx_byte  (rx_byte),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	// Frame state machine and decode. Each byte updates the state once; a
	// report is produced for a header reject, a frame end or an overlong frame.
	xcfd_frame_core #(
		.MAX_FRAME_LEN (MAX_FRAME_LEN)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.byte_s1   (byte_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	// The result register decouples the output request from the input side.
	xcfd_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (en && res_valid),
		.res       (res),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.blocked   (blocked),
		.res_q     (res_q)
	);

	assign status      = res_q.status;
	assign order_code  = res_q.order_code;
	assign pump_number = res_q.pump_number;
	assign year        = res_q.year;
	assign month       = res_q.month;
	assign day         = res_q.day;
	assign hour        = res_q.hour;
	assign minute      = res_q.minute;
	assign second      = res_q.second;

endmodule

`default_nettype wire

// ===== tb/xor_checked_frame_decoder_unit_tb.sv =====
// Self-checking testbench for xor_checked_frame_decoder_unit, the serial frame decoder.
// Uses xcfd_pkg for the status codes, the framing bytes and the report record.
// It holds its own frame predictor and checks each report against it.

module xor_checked_frame_decoder_unit_tb
	import xcfd_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	// Roughly how many bytes the run pushes into the decoder.
	localparam int unsigned RX_BYTE_TARGET = 1550;

	// One row of the directed part. When the report it causes is an error code
	// with all data fields zero, the row carries that status by hand. Every
	// other report comes from the predictor.
	typedef struct packed {
		logic [7:0] rx;
		logic       hand_typed;
		logic [2:0] hand_status;
	} directed_row_t;

	localparam int unsigned NUM_DIRECTED = 24;
	localparam directed_row_t DIRECTED_ROWS [0:NUM_DIRECTED-1] = '{
		// First request after reset: bad lead byte, then a good one.
		'{8'h00, 1'b0, ST_OK}, '{8'hAF, 1'b1, ST_HDR_REJECT},
		// Good lead byte, bad second byte.
		'{8'hAF, 1'b0, ST_OK}, '{8'h00, 1'b1, ST_HDR_REJECT},
		// All-ones bytes in both header positions.
		'{8'hFF, 1'b0, ST_OK}, '{8'hFF, 1'b1, ST_HDR_REJECT},
		// Header followed straight by the end marker: far too short.
		'{8'hAF, 1'b0, ST_OK}, '{8'hAF, 1'b0, ST_OK},
		'{8'hFA, 1'b0, ST_OK}, '{8'hFA, 1'b1, ST_TOO_SHORT},
		// Minimum length frame with extreme data and an invalid BCD second.
		'{8'hAF, 1'b0, ST_OK}, '{8'hAF, 1'b0, ST_OK},
		'{8'hFF, 1'b0, ST_OK}, '{8'h00, 1'b0, ST_OK},
		'{8'h99, 1'b0, ST_OK}, '{8'h99, 1'b0, ST_OK},
		'{8'h12, 1'b0, ST_OK}, '{8'h31, 1'b0, ST_OK},
		'{8'h23, 1'b0, ST_OK}, '{8'h59, 1'b0, ST_OK},
		'{8'hA5, 1'b0, ST_OK}, '{8'h03, 1'b0, ST_OK},
		'{8'hFA, 1'b0, ST_OK}, '{8'hFA, 1'b0, ST_OK}
	};

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  rx_byte;
	logic        out_valid;
	logic        out_stall;
	logic [2:0]  status;
	logic [7:0]  order_code;
	logic [7:0]  pump_number;
	logic [13:0] year;
	logic [6:0]  month;
	logic [6:0]  day;
	logic [6:0]  hour;
	logic [6:0]  minute;
	logic [6:0]  second;

	xor_checked_frame_decoder_unit i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.rx_byte     (rx_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.order_code  (order_code),
		.pump_number (pump_number),
		.year        (year),
		.month       (month),
		.day         (day),
		.hour        (hour),
		.minute      (minute),
		.second      (second)
	);

	// Predictor state: a copy of what the decoder keeps about the current frame.
	int unsigned  frame_pos;
	bit           lead_was_hdr;
	logic [7:0]   chk_accum;
	logic [7:0]   last_bytes [3];
	logic [7:0]   field_bytes [PAYLOAD_LEN];

	// Reports that the decoder still owes, oldest first.
	xcfd_result_t pending_reports [$];

	int unsigned  bytes_sent;
	int unsigned  sender_idle_pct;
	int unsigned  recv_stall_pct;
	bit           failed = 1'b0;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Two BCD digits to binary; ok drops when either nibble is above nine.
	function automatic logic [6:0] bcd_byte_value(input logic [7:0] v, output bit ok);
		ok = (v[7:4] < 4'd10) && (v[3:0] < 4'd10);
		return ok ? 7'(int'(v[7:4]) * 10 + int'(v[3:0])) : 7'd0;
	endfunction

	function automatic void clear_frame();
		frame_pos = 0;
		lead_was_hdr = 1'b0;
		chk_accum = 8'h00;
		last_bytes = '{8'h00, 8'h00, 8'h00};
	endfunction

	// Advances the predicted decoder by one byte. Returns 1 when the byte
	// closes or rejects a frame, with the report it must produce in rep.
	function automatic bit decode_rx_byte(input logic [7:0] b, output xcfd_result_t rep);
		int unsigned n;
		bit ok_hi, ok_lo;
		logic [6:0] yr_hi, yr_lo;
		rep = '0;
		last_bytes[2] = last_bytes[1];
		last_bytes[1] = last_bytes[0];
		last_bytes[0] = b;
		if (frame_pos == 0) begin
			lead_was_hdr = (b == HDR_BYTE);
			frame_pos = 1;
			return 1'b0;
		end
		if (frame_pos == 1) begin
			if (!lead_was_hdr || b != HDR_BYTE) begin
				rep.status = ST_HDR_REJECT;
				clear_frame();
				return 1'b1;
			end
			frame_pos = 2;
			return 1'b0;
		end
		chk_accum ^= b;
		if (frame_pos < PAYLOAD_FIRST + PAYLOAD_LEN)
			field_bytes[frame_pos - PAYLOAD_FIRST] = b;
		n = frame_pos + 1;
		if (last_bytes[0] == END_BYTE && last_bytes[1] == END_BYTE) begin
			if (n < MIN_FRAME_LEN) begin
				rep.status = ST_TOO_SHORT;
			end else begin
				// The accumulator also holds the checksum byte and both end
				// markers; take them out before comparing.
				rep.status = ((chk_accum ^ last_bytes[0] ^ last_bytes[1] ^ last_bytes[2])
					== last_bytes[2]) ? ST_OK : ST_CSUM_BAD;
				rep.order_code = field_bytes[0];
				rep.pump_number = field_bytes[1];
				yr_hi = bcd_byte_value(field_bytes[2], ok_hi);
				yr_lo = bcd_byte_value(field_bytes[3], ok_lo);
				rep.year = (ok_hi && ok_lo) ? 14'(int'(yr_hi) * 100 + int'(yr_lo)) : 14'd0;
				rep.month = bcd_byte_value(field_bytes[4], ok_hi);
				rep.day = bcd_byte_value(field_bytes[5], ok_hi);
				rep.hour = bcd_byte_value(field_bytes[6], ok_hi);
				rep.minute = bcd_byte_value(field_bytes[7], ok_hi);
				rep.second = bcd_byte_value(field_bytes[8], ok_hi);
			end
			clear_frame();
			return 1'b1;
		end
		if (n >= MAX_FRAME_LEN_DEF) begin
			rep.status = ST_TOO_LONG;
			clear_frame();
			return 1'b1;
		end
		frame_pos = n;
		return 1'b0;
	endfunction

	// Mostly valid BCD digits, with the odd nibble above nine.
	function automatic logic [7:0] random_bcd_byte();
		logic [3:0] hi, lo;
		hi = ($urandom_range(0, 99) < 90) ? 4'($urandom_range(0, 9)) : 4'($urandom_range(10, 15));
		lo = ($urandom_range(0, 99) < 90) ? 4'($urandom_range(0, 9)) : 4'($urandom_range(10, 15));
		return {hi, lo};
	endfunction

	// Idle rates follow the progress of the run: sender light and receiver
	// heavy, then the reverse, then full speed on both sides.
	function automatic void update_idle_rates();
		if (bytes_sent < RX_BYTE_TARGET / 3) begin
			sender_idle_pct = 34;
			recv_stall_pct = 66;
		end else if (bytes_sent < 2 * RX_BYTE_TARGET / 3) begin
			sender_idle_pct = 66;
			recv_stall_pct = 34;
		end else begin
			sender_idle_pct = 0;
			recv_stall_pct = 0;
		end
	endfunction

	// Offers one byte and returns at the edge where it is accepted. The
	// expected report, if any, is queued at that same edge.
	task automatic send_request(input logic [7:0] b, input bit hand_typed,
		input logic [2:0] hand_status);
		xcfd_result_t rep;
		bit has_rep;
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		has_rep = decode_rx_byte(b, rep);
		if (hand_typed) begin
			rep = '0;
			rep.status = hand_status;
			pending_reports.push_back(rep);
		end else if (has_rep) begin
			pending_reports.push_back(rep);
		end
		bytes_sent++;
		update_idle_rates();
	endtask

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			failed = 1'b1;
		end
	endtask

	// Receiver: stalls at random and checks every accepted report against
	// the oldest one still owed. The values read here are those from before
	// the edge, since every input changes through a nonblocking assignment.
	always @(posedge clk) begin
		xcfd_result_t want;
		out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
		if (arst_n && out_valid && !out_stall) begin
			if (pending_reports.size() == 0) begin
				$error("report with status %0d arrived while none was expected", status);
				failed = 1'b1;
			end else begin
				want = pending_reports.pop_front();
				check_field("status", want.status, status);
				check_field("order_code", want.order_code, order_code);
				check_field("pump_number", want.pump_number, pump_number);
				check_field("year", want.year, year);
				check_field("month", want.month, month);
				check_field("day", want.day, day);
				check_field("hour", want.hour, hour);
				check_field("minute", want.minute, minute);
				check_field("second", want.second, second);
			end
		end
	end

	// Stimulus: reset, the directed table, then random frames.
	initial begin
		logic [7:0] frame_q [$];
		logic [7:0] csum;
		logic [7:0] fill;
		int unsigned pick;
		int unsigned extra;
		int unsigned frame_idx;
		arst_n = 1'b0;
		in_valid = 1'b0;
		rx_byte = 8'h00;
		bytes_sent = 0;
		frame_idx = 0;
		clear_frame();
		field_bytes = '{default: 8'h00};
		update_idle_rates();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < NUM_DIRECTED; i++)
			send_request(DIRECTED_ROWS[i].rx, DIRECTED_ROWS[i].hand_typed,
				DIRECTED_ROWS[i].hand_status);

		// Most frames are well formed with random content, so that the checksum
		// and the BCD decoding are reached often; the rest are short frames,
		// broken headers, noise and the occasional frame that never ends.
		while (bytes_sent < RX_BYTE_TARGET) begin
			frame_q.delete();
			pick = (frame_idx == 0) ? 99 : $urandom_range(0, 99);
			if (pick < 65) begin
				frame_q.push_back(HDR_BYTE);
				frame_q.push_back(HDR_BYTE);
				frame_q.push_back(8'($urandom));
				frame_q.push_back(8'($urandom));
				repeat (PAYLOAD_LEN - 2) frame_q.push_back(random_bcd_byte());
				// Extra bytes before the checksum; a few frames run close to
				// the length limit.
				extra = $urandom_range(0, 99);
				if (extra < 88)
					extra = $urandom_range(0, 6);
				else if (extra < 98)
					extra = $urandom_range(7, 40);
				else
					extra = $urandom_range(MAX_FRAME_LEN_DEF - 25, MAX_FRAME_LEN_DEF - 14);
				repeat (extra) frame_q.push_back(8'($urandom));
				csum = 8'h00;
				for (int k = PAYLOAD_FIRST; k < frame_q.size(); k++)
					csum ^= frame_q[k];
				if (pick >= 50)
					csum ^= 8'($urandom_range(1, 255));
				frame_q.push_back(csum);
				frame_q.push_back(END_BYTE);
				frame_q.push_back(END_BYTE);
			end else if (pick < 75) begin
				frame_q.push_back(HDR_BYTE);
				frame_q.push_back(HDR_BYTE);
				repeat ($urandom_range(0, MIN_FRAME_LEN - 5)) begin
					fill = 8'($urandom);
					frame_q.push_back((fill == END_BYTE) ? 8'h00 : fill);
				end
				frame_q.push_back(END_BYTE);
				frame_q.push_back(END_BYTE);
			end else if (pick < 88) begin
				// Noise in pairs keeps the decoder aligned with what follows, unless a pair is two header bytes.
				repeat (2 * $urandom_range(1, 2)) begin
					fill = 8'($urandom);
					frame_q.push_back(($urandom_range(0, 3) == 0) ? HDR_BYTE : fill);
				end
			end else if (pick < 98) begin
				frame_q.push_back(HDR_BYTE);
				frame_q.push_back(8'($urandom));
			end else begin
				// Header and then filler free of the end marker until the
				// length limit cuts the frame off.
				frame_q.push_back(HDR_BYTE);
				frame_q.push_back(HDR_BYTE);
				repeat (MAX_FRAME_LEN_DEF - 2) begin
					fill = 8'($urandom);
					frame_q.push_back((fill == END_BYTE) ? 8'hFB : fill);
				end
			end
			foreach (frame_q[k])
				send_request(frame_q[k], 1'b0, ST_OK);
			frame_idx++;
		end

		in_valid <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
		// Run on after the last owed report has been taken, so that a stray
		// report would still be caught.
		repeat (10) @(posedge clk);
		if (!failed)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// Watchdog: far beyond the slowest correct run under the heaviest stalls.
	initial begin
		#5ms;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
